### design/two_voice_tone_sequencer_unit_assert.svh
// assertion macros for the sequencer unit
`ifndef TWO_VOICE_TONE_SEQUENCER_UNIT_ASSERT_SVH
`define TWO_VOICE_TONE_SEQUENCER_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define TVTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvts check failed");

// next-cycle implication
`define TVTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvts check failed");

`endif

### design/tvts_pkg.sv
`default_nettype none
package tvts_pkg;
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_STOP  = 2'd3;

    localparam logic [2:0] REG_BPM    = 3'd0;
    localparam logic [2:0] REG_VOLUME = 3'd1;
    localparam logic [2:0] REG_CLK_A  = 3'd2;
    localparam logic [2:0] REG_CLK_B  = 3'd3;
    localparam logic [2:0] REG_LENGTH = 3'd4;

    // note steps per voice; step_index and step positions are sized for this
    localparam int MAX_STEPS = 256;

    localparam int ELAPSED_W = 22;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
    localparam logic [15:0] BPM_DEFAULT = 16'd120;
    localparam logic [3:0] VOLUME_MAX = 4'd10;
    localparam logic [35:0] MS_SCALE = 36'd240000;
    localparam int DIV_W = 36;

    // request and answer of the shared serial divider
    typedef struct packed {
        logic            start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

### design/two_voice_tone_sequencer_unit.sv
`default_nettype none
// Two-voice tone sequencer. Mode 1 items write a note entry, mode 2 starts both
// voices at step 0 (or only stops when the melody length is zero), mode 3 stops,
// mode 0 is the millisecond tick. Each item gives one result transfer. Every
// note length and prescaler goes through one shared 36-bit restoring divider
// that makes one quotient bit per cycle, reading the note store one word at a
// time. No new item is taken until the result is taken.
module two_voice_tone_sequencer_unit
    import tvts_pkg::*;
#(
    parameter int RELOAD_VALUE = 1000
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [29:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  step_index,
    input  wire logic        voice_select,
    input  wire logic [15:0] note_hz,
    input  wire logic [15:0] note_length,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      a_prescale,
    output logic [5:0]       a_compare,
    output logic             a_reload,
    output logic [15:0]      b_prescale,
    output logic [5:0]       b_compare,
    output logic             b_reload,
    output logic             a_active,
    output logic             b_active,
    output logic             seq_playing
);
    `include "two_voice_tone_sequencer_unit_assert.svh"

    localparam int AW = $clog2(MAX_STEPS);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_VOICE = 4'd1;
    localparam logic [3:0] ST_RDLEN = 4'd2;
    localparam logic [3:0] ST_LEN   = 4'd3;
    localparam logic [3:0] ST_LWAIT = 4'd4;
    localparam logic [3:0] ST_RDTON = 4'd5;
    localparam logic [3:0] ST_TONE  = 4'd6;
    localparam logic [3:0] ST_DIV1  = 4'd7;
    localparam logic [3:0] ST_DIV2  = 4'd8;
    localparam logic [3:0] ST_NEXTV = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;
    localparam logic [3:0] ST_RDWT  = 4'd11;
    localparam logic [3:0] ST_TWAIT = 4'd12;

    logic [31:0] store [2*MAX_STEPS];
    logic [31:0] rd_data_reg;
    logic [AW:0] rd_addr;
    logic        rd_en;

    logic [15:0] bpm_reg;
    logic [3:0]  vol_reg;
    logic [29:0] clka_reg, clkb_reg;
    logic [8:0]  mlen_reg;

    logic [3:0]  st_reg, st_next;
    logic [1:0]  mode_reg, mode_next;
    logic        v_reg, v_next;
    logic [8:0]  pos_reg [2];
    logic [8:0]  pos_next [2];
    logic [ELAPSED_W-1:0] el_reg [2];
    logic [ELAPSED_W-1:0] el_next [2];
    logic [1:0]  act_reg, act_next;
    logic        run_reg, run_next;
    logic [15:0] psc_reg [2];
    logic [15:0] psc_next [2];
    logic [5:0]  cmp_reg [2];
    logic [5:0]  cmp_next [2];
    logic [1:0]  rl_reg, rl_next;
    logic        ov_reg, ov_next;
    logic [DIV_W-1:0] q1_reg, q1_next;

    div_req_t dreq;
    div_rsp_t drsp;

    logic [8:0]  eff_len;
    logic [3:0]  vol_eff;
    logic [29:0] clk_sel;
    logic [15:0] bpm_eff;
    logic        pos_ok;
    logic [8:0]  pos_inc;
    logic [DIV_W-1:0] q2;
    logic [15:0] freq;
    logic        accept;

    tvts_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign accept  = in_valid && !in_stall;
    assign in_stall = (st_reg != ST_IDLE) || ov_reg;
    assign eff_len = (mlen_reg > 9'(MAX_STEPS)) ? 9'(MAX_STEPS) : mlen_reg;
    assign vol_eff = (vol_reg > VOLUME_MAX) ? VOLUME_MAX : vol_reg;
    assign clk_sel = v_reg ? clkb_reg : clka_reg;
    assign bpm_eff = (bpm_reg == 16'd0) ? BPM_DEFAULT : bpm_reg;
    assign pos_ok  = {3'd0, pos_reg[v_reg]} < 12'(MAX_STEPS);
    assign pos_inc = pos_reg[v_reg] + 9'd1;
    assign q2      = drsp.quotient;
    assign freq    = rd_data_reg[15:0];
    assign rd_addr = {pos_reg[v_reg][AW-1:0], v_reg};

    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_WRITE && {1'b0, step_index} < 9'(MAX_STEPS))
            store[{step_index[AW-1:0], voice_select}] <= {note_length, note_hz};
        if (rd_en)
            rd_data_reg <= pos_ok ? store[rd_addr] : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpm_reg  <= BPM_DEFAULT;
            vol_reg  <= 4'd5;
            clka_reg <= 30'd72000000;
            clkb_reg <= 30'd72000000;
            mlen_reg <= 9'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BPM:    bpm_reg  <= cfg_data[15:0];
                REG_VOLUME: vol_reg  <= cfg_data[3:0];
                REG_CLK_A:  clka_reg <= cfg_data;
                REG_CLK_B:  clkb_reg <= cfg_data;
                REG_LENGTH: mlen_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        mode_next = mode_reg;
        v_next    = v_reg;
        pos_next  = pos_reg;
        el_next   = el_reg;
        act_next  = act_reg;
        run_next  = run_reg;
        psc_next  = psc_reg;
        cmp_next  = cmp_reg;
        rl_next   = rl_reg;
        ov_next   = ov_reg;
        q1_next   = q1_reg;
        rd_en     = 1'b0;
        dreq      = '0;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;
                    rl_next   = 2'b00;
                    v_next    = 1'b0;
                    case (mode)
                        MODE_WRITE: st_next = ST_OUT;
                        MODE_TICK:  st_next = run_reg ? ST_VOICE : ST_OUT;
                        default:
                        begin
                            run_next    = 1'b0;
                            act_next    = 2'b00;
                            cmp_next[0] = 6'd0;
                            cmp_next[1] = 6'd0;
                            rl_next     = 2'b11;
                            if (mode == MODE_START && eff_len != 9'd0)
                            begin
                                run_next    = 1'b1;
                                act_next    = 2'b11;
                                pos_next[0] = 9'd0;
                                pos_next[1] = 9'd0;
                                el_next[0]  = '0;
                                el_next[1]  = '0;
                                st_next     = ST_RDTON;
                            end
                            else
                                st_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_VOICE:
            begin
                if (!act_reg[v_reg])
                    st_next = ST_NEXTV;
                else
                begin
                    if (el_reg[v_reg] != ELAPSED_MAX)
                        el_next[v_reg] = el_reg[v_reg] + 1'b1;
                    rd_en   = 1'b1;
                    st_next = ST_RDLEN;
                end
            end
            ST_RDLEN: st_next = ST_LEN;
            ST_LEN:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = 36'(MS_SCALE * 36'(rd_data_reg[31:16]));
                dreq.divisor  = {8'd0, bpm_eff, 12'd0};
                st_next       = ST_LWAIT;
            end
            ST_LWAIT:
            begin
                if (drsp.done)
                begin
                    if ({14'd0, el_reg[v_reg]} >=
                        ((q2 == '0) ? 36'd1 : q2))
                    begin
                        pos_next[v_reg] = pos_inc;
                        el_next[v_reg]  = '0;
                        if (pos_inc >= eff_len)
                        begin
                            act_next[v_reg] = 1'b0;
                            rl_next[v_reg]  = 1'b1;
                            cmp_next[v_reg] = 6'd0;
                            st_next         = ST_NEXTV;
                        end
                        else
                            st_next = ST_RDTON;
                    end
                    else
                        st_next = ST_NEXTV;
                end
            end
            ST_RDTON:
            begin
                rd_en   = 1'b1;
                st_next = ST_RDWT;
            end
            ST_RDWT: st_next = ST_TONE;
            ST_TONE:
            begin
                rl_next[v_reg] = 1'b1;
                if (freq == 16'd0 || vol_eff == 4'd0)
                begin
                    cmp_next[v_reg] = 6'd0;
                    st_next         = (mode_reg == MODE_START) ? ST_NEXTV : ST_NEXTV;
                end
                else
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = {6'd0, clk_sel};
                    dreq.divisor  = {20'd0, freq};
                    st_next       = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (drsp.done)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = q2;
                    dreq.divisor  = DIV_W'(RELOAD_VALUE + 1);
                    st_next       = ST_TWAIT;
                end
            end
            ST_TWAIT:
            begin
                if (drsp.done)
                begin
                    q1_next = q2;
                    st_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (q1_reg == '0)
                    psc_next[v_reg] = 16'd0;
                else if (q1_reg > 36'd65535)
                    psc_next[v_reg] = 16'd65534;
                else
                    psc_next[v_reg] = q1_reg[15:0] - 16'd1;
                cmp_next[v_reg] = 6'(vol_eff) * 6'd5;
                st_next = ST_NEXTV;
            end
            ST_NEXTV:
            begin
                if (v_reg == 1'b0)
                begin
                    v_next  = 1'b1;
                    st_next = (mode_reg == MODE_START) ? ST_RDTON : ST_VOICE;
                end
                else
                begin
                    if (mode_reg == MODE_TICK)
                        run_next = |act_reg;
                    st_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            mode_reg   <= MODE_TICK;
            v_reg      <= 1'b0;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            el_reg[0]  <= '0;
            el_reg[1]  <= '0;
            act_reg    <= 2'b00;
            run_reg    <= 1'b0;
            psc_reg[0] <= '0;
            psc_reg[1] <= '0;
            cmp_reg[0] <= '0;
            cmp_reg[1] <= '0;
            rl_reg     <= 2'b00;
            ov_reg     <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            mode_reg <= mode_next;
            v_reg    <= v_next;
            pos_reg  <= pos_next;
            el_reg   <= el_next;
            act_reg  <= act_next;
            run_reg  <= run_next;
            psc_reg  <= psc_next;
            cmp_reg  <= cmp_next;
            rl_reg   <= rl_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q1_reg <= q1_next;
    end

    assign out_valid   = ov_reg;
    assign a_prescale  = psc_reg[0];
    assign a_compare   = cmp_reg[0];
    assign a_reload    = rl_reg[0];
    assign b_prescale  = psc_reg[1];
    assign b_compare   = cmp_reg[1];
    assign b_reload    = rl_reg[1];
    assign a_active    = act_reg[0];
    assign b_active    = act_reg[1];
    assign seq_playing = run_reg;

    `TVTS_ASSERT_IMP(a_no_accept_busy, st_reg != ST_IDLE, in_stall)
    `TVTS_ASSERT_IMP(a_run_has_voice, out_valid && seq_playing, a_active || b_active)
    `TVTS_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
endmodule
`default_nettype wire

### design/tvts_divider.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module tvts_divider
    import tvts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[DIV_W-1]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 6'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DIV_W])
                rem_next = {rem_reg[DIV_W-2:0], quot_reg[DIV_W-1]};
            else
                rem_next = trial[DIV_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], ~trial[DIV_W]};
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;
endmodule
`default_nettype wire

### dv/tb_two_voice_tone_sequencer_unit.sv
`default_nettype none
module tb_two_voice_tone_sequencer_unit;
    import tvts_pkg::*;

    localparam int STEPS  = MAX_STEPS;
    localparam int RELOAD = 1000;

    typedef struct packed {
        logic [15:0] a_psc;
        logic [5:0]  a_cmp;
        logic        a_rld;
        logic [15:0] b_psc;
        logic [5:0]  b_cmp;
        logic        b_rld;
        logic        a_act;
        logic        b_act;
        logic        playing;
    } tone_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [29:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [7:0]  step_index;
    logic        voice_select;
    logic [15:0] note_hz;
    logic [15:0] note_length;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] a_prescale;
    logic [5:0]  a_compare;
    logic        a_reload;
    logic [15:0] b_prescale;
    logic [5:0]  b_compare;
    logic        b_reload;
    logic        a_active;
    logic        b_active;
    logic        seq_playing;

    two_voice_tone_sequencer_unit DUT (.*);

    // predicted sequencer state
    logic [31:0] note_words [2*STEPS];
    logic [8:0]  seq_pos [2];
    logic [21:0] seq_elapsed [2];
    bit          voice_on [2];
    bit          seq_running;
    logic [15:0] held_psc [2];
    logic [5:0]  held_cmp [2];
    bit          rewrote [2];
    logic [15:0] tempo;
    logic [3:0]  volume;
    logic [29:0] timer_clk [2];
    logic [8:0]  melody_len;

    tone_result_t pending_tones [$];
    int errors;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [31:0] entry_at(logic [8:0] p, int v);
        if (p >= STEPS)
            return 32'd0;
        return note_words[p*2 + v];
    endfunction

    function automatic logic [21:0] note_len_ms(logic [15:0] dur);
        longint bpm;
        longint ms;
        bpm = (tempo == 0) ? 120 : tempo;
        ms = (longint'(240000) * dur) / (longint'(4096) * bpm);
        return (ms == 0) ? 22'd1 : ms[21:0];
    endfunction

    function automatic void load_tone(int v, logic [15:0] f);
        longint vol;
        longint psc;
        vol = (volume > 10) ? 10 : volume;
        rewrote[v] = 1'b1;
        if (f == 0 || vol == 0)
        begin
            held_cmp[v] = 6'd0;
            return;
        end
        psc = (longint'(timer_clk[v]) / f) / (RELOAD + 1);
        if (psc < 1)
            psc = 1;
        if (psc > 65535)
            psc = 65535;
        held_psc[v] = 16'(psc - 1);
        held_cmp[v] = 6'(vol * 5);
    endfunction

    function automatic void silence_all();
        seq_running = 1'b0;
        voice_on[0] = 1'b0;
        voice_on[1] = 1'b0;
        load_tone(0, 16'd0);
        load_tone(1, 16'd0);
    endfunction

    function automatic tone_result_t predict_tones(logic [1:0] m, logic [7:0] s,
                                                   logic vs, logic [15:0] hz,
                                                   logic [15:0] len);
        tone_result_t r;
        logic [8:0] eff;
        logic [31:0] ent;
        bit any;
        rewrote[0] = 1'b0;
        rewrote[1] = 1'b0;
        eff = (melody_len > STEPS) ? 9'(STEPS) : melody_len;
        if (m == MODE_WRITE)
            note_words[s*2 + vs] = {len, hz};
        else if (m == MODE_START)
        begin
            silence_all();
            if (eff != 0)
            begin
                seq_running = 1'b1;
                for (int v = 0; v < 2; v++)
                begin
                    seq_pos[v] = 0;
                    seq_elapsed[v] = 0;
                    voice_on[v] = 1'b1;
                    ent = entry_at(9'd0, v);
                    load_tone(v, ent[15:0]);
                end
            end
        end
        else if (m == MODE_STOP)
            silence_all();
        else if (seq_running)
        begin
            any = 1'b0;
            for (int v = 0; v < 2; v++)
            begin
                if (voice_on[v])
                begin
                    if (seq_elapsed[v] != ELAPSED_MAX)
                        seq_elapsed[v]++;
                    ent = entry_at(seq_pos[v], v);
                    if (seq_elapsed[v] >= note_len_ms(ent[31:16]))
                    begin
                        seq_pos[v] = seq_pos[v] + 1;
                        seq_elapsed[v] = 0;
                        if (seq_pos[v] >= eff)
                        begin
                            voice_on[v] = 1'b0;
                            load_tone(v, 16'd0);
                        end
                        else
                        begin
                            ent = entry_at(seq_pos[v], v);
                            load_tone(v, ent[15:0]);
                        end
                    end
                    if (voice_on[v])
                        any = 1'b1;
                end
            end
            seq_running = any;
        end
        r.a_psc = held_psc[0];
        r.a_cmp = held_cmp[0];
        r.a_rld = rewrote[0];
        r.b_psc = held_psc[1];
        r.b_cmp = held_cmp[1];
        r.b_rld = rewrote[1];
        r.a_act = voice_on[0];
        r.b_act = voice_on[1];
        r.playing = seq_running;
        return r;
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        tone_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tones.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_tones.pop_front();
                compare_field("a_prescale", e.a_psc, a_prescale);
                compare_field("a_compare", e.a_cmp, a_compare);
                compare_field("a_reload", e.a_rld, a_reload);
                compare_field("b_prescale", e.b_psc, b_prescale);
                compare_field("b_compare", e.b_cmp, b_compare);
                compare_field("b_reload", e.b_rld, b_reload);
                compare_field("a_active", e.a_act, a_active);
                compare_field("b_active", e.b_act, b_active);
                compare_field("seq_playing", e.playing, seq_playing);
            end
        end
    end

    // valid stays up after a transfer so back-to-back items need no gap
    task automatic send_item(logic [1:0] m, logic [7:0] s, logic vs,
                             logic [15:0] hz, logic [15:0] len);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        step_index   <= s;
        voice_select <= vs;
        note_hz      <= hz;
        note_length  <= len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_tones.push_back(predict_tones(m, s, vs, hz, len));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_tones.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [29:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BPM:    tempo = val[15:0];
            REG_VOLUME: volume = val[3:0];
            REG_CLK_A:  timer_clk[0] = val;
            REG_CLK_B:  timer_clk[1] = val;
            REG_LENGTH: melody_len = val[8:0];
            default: ;
        endcase
    endtask

    task automatic test_idle_modes();
        send_tick();
        send_item(MODE_START, 8'd0, 1'b0, 16'd0, 16'd0);   // empty melody
        send_item(MODE_STOP, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
        send_tick();
    endtask

    // every entry gets a short note so no read ever hits an unwritten word
    task automatic test_fill_store();
        for (int s = 0; s < STEPS; s++)
            for (int v = 0; v < 2; v++)
                send_item(MODE_WRITE, 8'(s), 1'(v), 16'($urandom_range(0, 5000)),
                          16'($urandom_range(0, 300)));
    endtask

    task automatic test_short_melody();
        send_item(MODE_WRITE, 8'd0, 1'b0, 16'd440, 16'd100);
        send_item(MODE_WRITE, 8'd0, 1'b1, 16'd0, 16'd0);      // rest, shortest note
        send_item(MODE_WRITE, 8'd1, 1'b0, 16'hFFFF, 16'd0);
        send_item(MODE_WRITE, 8'd1, 1'b1, 16'd1, 16'd50);
        write_reg(REG_BPM, 30'd4000);
        write_reg(REG_LENGTH, 30'd2);
        send_item(MODE_START, 8'd0, 1'b0, 16'd0, 16'd0);
        send_item(MODE_START, 8'd0, 1'b0, 16'd0, 16'd0);      // restart while playing
        for (int i = 0; i < 8 && seq_running; i++)
            send_tick();
    endtask

    task automatic test_register_extremes();
        send_item(MODE_WRITE, 8'd0, 1'b0, 16'hFFFF, 16'hFFFF);
        send_item(MODE_WRITE, 8'd0, 1'b1, 16'd1, 16'hFFFF);
        write_reg(REG_BPM, 30'd0);
        write_reg(REG_VOLUME, 30'd15);
        write_reg(REG_CLK_A, 30'd0);
        write_reg(REG_CLK_B, 30'h3FFFFFFF);
        write_reg(REG_LENGTH, 30'h1FF);
        send_item(MODE_START, 8'd0, 1'b0, 16'd0, 16'd0);
        send_tick();
        send_item(MODE_STOP, 8'd0, 1'b0, 16'd0, 16'd0);
        write_reg(REG_VOLUME, 30'd0);
        write_reg(REG_BPM, 30'hFFFF);
        write_reg(REG_LENGTH, 30'd256);
        send_item(MODE_START, 8'd0, 1'b0, 16'd0, 16'd0);
        send_tick();
        send_item(MODE_STOP, 8'd0, 1'b0, 16'd0, 16'd0);
        write_reg(REG_VOLUME, 30'd10);
        write_reg(REG_CLK_A, 30'd1);
    endtask

    task automatic play_random_melody();
        int len;
        int r;
        int ticks;
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        for (int s = 0; s < len; s++)
            for (int v = 0; v < 2; v++)
                send_item(MODE_WRITE, 8'(s), 1'(v),
                          ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom),
                          16'($urandom_range(0, 400)));
        write_reg(REG_BPM, 30'($urandom_range(3000, 65535)));
        write_reg(REG_LENGTH, 30'(len));
        if ($urandom_range(3) == 0)
            write_reg(REG_VOLUME, 30'($urandom_range(0, 15)));
        if ($urandom_range(3) == 0)
        begin
            write_reg(REG_CLK_A, 30'($urandom));
            write_reg(REG_CLK_B, 30'($urandom_range(1000, 1000000000)));
        end
        send_item(MODE_START, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        ticks = 0;
        while (seq_running && ticks < 400)
        begin
            r = $urandom_range(99);
            if (r < 2)
                send_item(MODE_STOP, 8'($urandom), 1'($urandom), 16'($urandom),
                          16'($urandom));
            else if (r < 4)
                send_item(MODE_START, 8'($urandom), 1'($urandom), 16'($urandom),
                          16'($urandom));
            else if (r < 7)
                // noise into steps past the melody, full field range
                send_item(MODE_WRITE, 8'($urandom_range(64, 255)), 1'($urandom),
                          16'($urandom), 16'($urandom));
            else
            begin
                send_tick();
                ticks++;
            end
        end
        send_tick();
    endtask

    task automatic test_random(int goal);
        while (items_sent < goal)
            play_random_melody();
    endtask

    initial
    begin
        errors = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_BPM;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_TICK;
        step_index = '0;
        voice_select = 1'b0;
        note_hz = '0;
        note_length = '0;
        for (int i = 0; i < 2*STEPS; i++)
            note_words[i] = '0;
        for (int v = 0; v < 2; v++)
        begin
            seq_pos[v] = '0;
            seq_elapsed[v] = '0;
            voice_on[v] = 1'b0;
            held_psc[v] = '0;
            held_cmp[v] = '0;
            timer_clk[v] = 30'd72000000;
        end
        seq_running = 1'b0;
        tempo = BPM_DEFAULT;
        volume = 4'd5;
        melody_len = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_modes();
        test_fill_store();
        test_short_melody();
        test_register_extremes();
        send_idle_pct = 23;
        recv_idle_pct = 74;
        test_random(items_sent + 400);
        send_idle_pct = 74;
        recv_idle_pct = 23;
        test_random(items_sent + 400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(1550);

        drain();
        repeat (250) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
